// File: rtl/omca_pkg.sv
// ----------------------------------------------------------------------------
// omca_pkg: shared types and constants
// Command and status types between controller and datapath, request codes,
// fixed-point limits and the 48-bit saturation helper.
// ----------------------------------------------------------------------------
package omca_pkg;

    localparam int IDX_W  = 4;   // row/column counters, hold up to 15
    localparam int ADDR_W = 6;   // packed covariance address, up to 64 entries
    localparam int STEP_W = 3;
    localparam int DATA_W = 48;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 24;
    localparam int DIV_W  = 49;
    localparam int DVS_W  = 25;

    localparam logic signed [DATA_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN48 = 48'sh8000_0000_0000;

    localparam logic KIND_GRAD = 1'b0;
    localparam logic KIND_HESS = 1'b1;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_TARGET = 2'd1,
        REQ_CLOSE  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // partial product selection of the shared 24x24 multiplier
    typedef enum logic [STEP_W-1:0] {
        MUL_LL  = 3'd0,
        MUL_LH  = 3'd1,
        MUL_HL  = 3'd2,
        MUL_HH  = 3'd3,
        MUL_NLO = 3'd4,
        MUL_NHI = 3'd5
    } mul_step_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_TARGET_WR,
        DP_DIFF,
        DP_DELTA_FIN,
        DP_PAIR_LOAD,
        DP_SCALE_START,
        DP_SCALE_FIN,
        DP_MUL,
        DP_MFIN,
        DP_COV_WB,
        DP_COUNT_INC,
        DP_GRAD_OUT,
        DP_COV_RD,
        DP_HESS_OUT,
        DP_CLEAR
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT,
        ST_S_DIFF,
        ST_S_DWAIT,
        ST_U_SCALE,
        ST_U_SWAIT,
        ST_U_MUL,
        ST_U_MFIN,
        ST_U_NMUL,
        ST_U_WB,
        ST_S_LAST,
        ST_P_SEL,
        ST_G_OUT,
        ST_H_SEL,
        ST_H_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t            op;
        logic              capture;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
        mul_step_t         step;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic signed [DATA_W-1:0] sat48(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((v[DATA_W+1:DATA_W-1] == 3'b000) || (v[DATA_W+1:DATA_W-1] == 3'b111)) begin
            r = v[DATA_W-1:0];
        end else if (v[DATA_W+1]) begin
            r = MIN48;
        end else begin
            r = MAX48;
        end
        return r;
    endfunction

endpackage

// File: rtl/omca_div.sv
// ----------------------------------------------------------------------------
// omca_div: iterative restoring divider
// Unsigned 49-bit by 25-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module omca_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [omca_pkg::DIV_W-1:0]  dividend,
    input  logic [omca_pkg::DVS_W-1:0]  divisor,
    output logic [omca_pkg::DIV_W-1:0]  quotient,
    output logic [omca_pkg::DVS_W-1:0]  remainder,
    output logic                        busy,
    output logic                        done
);
    import omca_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // subtract where it fits, shift in the quotient bit
            if (!trial[DVS_W+1]) begin
                rem_next = trial[DVS_W-1:0];
            end else begin
                rem_next = shifted[DVS_W-1:0];
            end
            quo_next = {quo_reg[DIV_W-2:0], ~trial[DVS_W+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

// File: rtl/omca_datapath.sv
// ----------------------------------------------------------------------------
// omca_datapath: accumulator datapath
// Means, deltas, targets, packed covariance memory, sample count, shared
// divider and 24x24 multiplier, and the output register.
// ----------------------------------------------------------------------------
module omca_datapath #(
    parameter int NUM_COEFFS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  omca_pkg::cmd_t                cmd,
    output omca_pkg::status_t             status,
    input  logic signed [omca_pkg::VAL_W-1:0] in_value,
    input  logic [15:0]                   beta,
    input  logic                          m_ready,
    output logic                          out_valid,
    output logic                          out_kind,
    output logic [2:0]                    out_row,
    output logic [2:0]                    out_col,
    output logic signed [omca_pkg::DATA_W-1:0] out_value,
    output logic                          out_last
);
    import omca_pkg::*;

    localparam int PS  = (NUM_COEFFS * (NUM_COEFFS + 1)) / 2;
    localparam int PAW = (PS > 1) ? $clog2(PS) : 1;
    localparam int IXW = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
    localparam int HW  = DATA_W / 2;

    logic signed [DATA_W-1:0] mean_reg   [NUM_COEFFS];
    logic signed [DATA_W-1:0] delta_reg  [NUM_COEFFS];
    logic signed [VAL_W-1:0]  target_reg [NUM_COEFFS];
    logic [DATA_W-1:0]        cov_mem    [PS];
    logic [PS-1:0]            vld_reg;
    logic [DATA_W-1:0]        rd_data_reg;
    logic                     rd_vld_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [VAL_W-1:0]  val_reg;

    logic [DATA_W-1:0]        a_reg, b_reg;
    logic                     neg_reg, dneg_reg, cneg_reg, mbig_reg;
    logic [DATA_W-1:0]        cmag_reg;
    logic signed [DATA_W-1:0] s_reg;
    logic [2*DATA_W-1:0]      acc_reg;

    logic                     out_valid_reg, out_kind_reg, out_last_reg;
    logic [2:0]               out_row_reg, out_col_reg;
    logic signed [DATA_W-1:0] out_value_reg;

    logic [IXW-1:0]           row_ix, col_ix;
    logic [PAW-1:0]           addr_ix;
    logic signed [DATA_W-1:0] x48, mean_sel, d48, c_eff, s48, wp48, h48, g48;
    logic signed [DATA_W:0]   diff49;
    logic [DIV_W-1:0]         diff_mag;
    logic signed [DATA_W+1:0] q50;
    logic [DATA_W-1:0]        d_mag, c_mag, da_mag, db_mag;
    logic [DATA_W:0]          s49;
    logic [HW-1:0]            mx, my;
    logic [DATA_W-1:0]        pp;
    logic [2*DATA_W-1:0]      pp_sh;
    logic [71:0]              prod72;
    logic                     wp_sat;
    logic [63:0]              hm64;
    logic [55:0]              hsh;
    logic                     div_start, div_busy, div_done;
    logic [DIV_W-1:0]         div_quo;
    logic [DVS_W-1:0]         div_rem;
    logic [DIV_W-1:0]         div_dividend;
    logic                     cov_rd;

    assign row_ix  = cmd.row[IXW-1:0];
    assign col_ix  = cmd.col[IXW-1:0];
    assign addr_ix = cmd.addr[PAW-1:0];

    // sample delta path
    assign x48      = {val_reg, 16'h0000};
    assign mean_sel = mean_reg[row_ix];
    assign diff49   = {x48[DATA_W-1], x48} - {mean_sel[DATA_W-1], mean_sel};
    assign diff_mag = diff49[DATA_W] ? DIV_W'(-diff49) : DIV_W'(diff49);
    assign q50      = dneg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign d48      = sat48(q50);
    assign d_mag    = d48[DATA_W-1] ? DATA_W'(-d48) : DATA_W'(d48);
    assign da_mag   = delta_reg[row_ix][DATA_W-1] ? DATA_W'(-delta_reg[row_ix])
                                                  : DATA_W'(delta_reg[row_ix]);
    assign db_mag   = delta_reg[col_ix][DATA_W-1] ? DATA_W'(-delta_reg[col_ix])
                                                  : DATA_W'(delta_reg[col_ix]);

    // covariance scaling: trunc(|c|*n/(n+1)) = |c| - ceil(|c|/(n+1))
    assign c_eff  = rd_vld_reg ? $signed(rd_data_reg) : '0;
    assign c_mag  = c_eff[DATA_W-1] ? DATA_W'(-c_eff) : DATA_W'(c_eff);
    assign s49    = {1'b0, cmag_reg} - div_quo - {{DATA_W{1'b0}}, (div_rem != '0)};
    assign s48    = cneg_reg ? -$signed(s49[DATA_W-1:0]) : $signed(s49[DATA_W-1:0]);

    // shared multiplier
    always_comb begin
        case (cmd.step)
            MUL_LL:  begin mx = a_reg[HW-1:0];      my = b_reg[HW-1:0];      end
            MUL_LH:  begin mx = a_reg[HW-1:0];      my = b_reg[DATA_W-1:HW]; end
            MUL_HL:  begin mx = a_reg[DATA_W-1:HW]; my = b_reg[HW-1:0];      end
            MUL_HH:  begin mx = a_reg[DATA_W-1:HW]; my = b_reg[DATA_W-1:HW]; end
            MUL_NLO: begin mx = a_reg[HW-1:0];      my = count_reg;          end
            MUL_NHI: begin mx = a_reg[DATA_W-1:HW]; my = count_reg;          end
            default: begin mx = '0;                 my = '0;                 end
        endcase
    end
    assign pp = mx * my;

    always_comb begin
        case (cmd.step)
            MUL_LH, MUL_HL, MUL_NHI: pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
            MUL_HH:                  pp_sh = {pp, {DATA_W{1'b0}}};
            default:                 pp_sh = {{DATA_W{1'b0}}, pp};
        endcase
    end

    // weighted product n*trunc(|a||b|/2^32) with saturation
    assign prod72 = acc_reg[71:0];
    assign wp_sat = mbig_reg | (|prod72[71:DATA_W-1]);
    always_comb begin
        if (count_reg == '0) begin
            wp48 = '0;
        end else if (wp_sat) begin
            wp48 = neg_reg ? MIN48 : MAX48;
        end else begin
            wp48 = neg_reg ? -$signed(prod72[DATA_W-1:0]) : $signed(prod72[DATA_W-1:0]);
        end
    end

    // outputs of a close run
    assign g48  = sat48({{2{1'b0}}, {target_reg[row_ix], 16'h0000}}
                        - {{2{mean_sel[DATA_W-1]}}, mean_sel}
                        + {{2{target_reg[row_ix][VAL_W-1]}}, {DATA_W{1'b0}}});
    assign hm64 = c_mag * beta;
    assign hsh  = hm64[63:8];
    always_comb begin
        if (|hsh[55:DATA_W-1]) begin
            h48 = c_eff[DATA_W-1] ? MIN48 : MAX48;
        end else begin
            h48 = c_eff[DATA_W-1] ? -$signed(hsh[DATA_W-1:0]) : $signed(hsh[DATA_W-1:0]);
        end
    end

    assign div_start    = (cmd.op == DP_DIFF) || (cmd.op == DP_SCALE_START);
    assign div_dividend = (cmd.op == DP_DIFF) ? diff_mag : {1'b0, c_mag};
    assign cov_rd       = (cmd.op == DP_DIFF) || (cmd.op == DP_PAIR_LOAD)
                          || (cmd.op == DP_COV_RD);

    omca_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   ({1'b0, count_reg} + DVS_W'(1)),
        .quotient  (div_quo),
        .remainder (div_rem),
        .busy      (div_busy),
        .done      (div_done)
    );

    // control state: count, valid bits, means, targets, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_COEFFS; k++) begin
                mean_reg[k]   <= '0;
                target_reg[k] <= '0;
            end
        end else begin
            if ((cmd.op == DP_GRAD_OUT) || (cmd.op == DP_HESS_OUT)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                DP_TARGET_WR: target_reg[row_ix] <= val_reg;
                DP_DELTA_FIN: mean_reg[row_ix] <= sat48({{2{mean_sel[DATA_W-1]}}, mean_sel}
                                                        + {{2{d48[DATA_W-1]}}, d48});
                DP_COV_WB:    vld_reg[addr_ix] <= 1'b1;
                DP_COUNT_INC: begin
                    if (count_reg != {CNT_W{1'b1}}) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                DP_CLEAR: begin
                    count_reg <= '0;
                    vld_reg   <= '0;
                    for (int k = 0; k < NUM_COEFFS; k++) begin
                        mean_reg[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            val_reg <= in_value;
        end
        if (cov_rd) begin
            rd_data_reg <= cov_mem[addr_ix];
            rd_vld_reg  <= vld_reg[addr_ix];
        end
        if (cmd.op == DP_COV_WB) begin
            cov_mem[addr_ix] <= sat48({{2{s_reg[DATA_W-1]}}, s_reg}
                                      + {{2{wp48[DATA_W-1]}}, wp48});
        end
        case (cmd.op)
            DP_DIFF:      dneg_reg <= diff49[DATA_W];
            DP_DELTA_FIN: begin
                delta_reg[row_ix] <= d48;
                a_reg   <= d_mag;
                b_reg   <= d_mag;
                neg_reg <= 1'b0;
            end
            DP_PAIR_LOAD: begin
                a_reg   <= da_mag;
                b_reg   <= db_mag;
                neg_reg <= delta_reg[row_ix][DATA_W-1] ^ delta_reg[col_ix][DATA_W-1];
            end
            DP_SCALE_START: begin
                cmag_reg <= c_mag;
                cneg_reg <= c_eff[DATA_W-1];
            end
            DP_SCALE_FIN: s_reg <= s48;
            DP_MUL: begin
                if ((cmd.step == MUL_LL) || (cmd.step == MUL_NLO)) begin
                    acc_reg <= pp_sh;
                end else begin
                    acc_reg <= acc_reg + pp_sh;
                end
            end
            DP_MFIN: begin
                a_reg    <= acc_reg[79:32];
                mbig_reg <= |acc_reg[95:80];
            end
            DP_GRAD_OUT: begin
                out_kind_reg  <= KIND_GRAD;
                out_row_reg   <= cmd.row[2:0];
                out_col_reg   <= cmd.row[2:0];
                out_value_reg <= g48;
                out_last_reg  <= cmd.last;
            end
            DP_HESS_OUT: begin
                out_kind_reg  <= KIND_HESS;
                out_row_reg   <= cmd.row[2:0];
                out_col_reg   <= cmd.col[2:0];
                out_value_reg <= h48;
                out_last_reg  <= cmd.last;
            end
            default: ;
        endcase
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_ready;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd.op == DP_GRAD_OUT) || (cmd.op == DP_HESS_OUT)) |-> status.out_free)
        else $error("output item overwritten before taken");
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_COUNT_INC) |=> (count_reg >= $past(count_reg)))
        else $error("sample count wrapped");
`endif

endmodule

// File: rtl/omca_ctrl.sv
// ----------------------------------------------------------------------------
// omca_ctrl: sequencing controller
// Decodes requests and steps the datapath through delta, covariance update,
// off-diagonal sweep and the close run.
// ----------------------------------------------------------------------------
module omca_ctrl #(
    parameter int NUM_COEFFS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  omca_pkg::req_t       in_req,
    input  logic [2:0]           in_index,
    input  logic                 in_last,
    input  logic                 diag_only,
    input  omca_pkg::status_t    status,
    output omca_pkg::cmd_t       cmd
);
    import omca_pkg::*;

    localparam logic [IDX_W-1:0] NC_IX   = IDX_W'(NUM_COEFFS);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(NUM_COEFFS - 1);

    ctrl_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next, idx_reg, idx_next;
    logic [ADDR_W-1:0] p_reg, p_next;
    mul_step_t         step_reg, step_next;
    logic              last_reg, last_next, pairs_reg, pairs_next;
    logic [IDX_W-1:0]  adv_i, adv_j;
    logic [IDX_W-1:0]  in_idx;
    logic [ADDR_W-1:0] diag_addr;

    function automatic logic [ADDR_W-1:0] tri_diag(input logic [IDX_W-1:0] ix);
        int ii;
        ii = int'(ix);
        return ADDR_W'(ii * NUM_COEFFS - ((ii * (ii - 1)) >> 1));
    endfunction

    assign in_idx    = {1'b0, in_index};
    assign diag_addr = tri_diag(idx_reg);

    // walk the upper triangle in packed order
    always_comb begin
        if (j_reg == LAST_IX) begin
            adv_i = i_reg + 1'b1;
            adv_j = i_reg + 1'b1;
        end else begin
            adv_i = i_reg;
            adv_j = j_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        pairs_next = pairs_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next  = in_idx;
                    last_next = in_last;
                    case (in_req)
                        REQ_SAMPLE: state_next = (in_idx < NC_IX) ? ST_S_DIFF : ST_S_LAST;
                        REQ_TARGET: state_next = (in_idx < NC_IX) ? ST_TGT : ST_IDLE;
                        REQ_CLOSE: begin
                            i_next     = '0;
                            state_next = ST_G_OUT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TGT: state_next = ST_IDLE;
            ST_S_DIFF: begin
                pairs_next = 1'b0;
                state_next = ST_S_DWAIT;
            end
            ST_S_DWAIT: if (status.div_done) state_next = ST_U_SCALE;
            ST_U_SCALE: state_next = ST_U_SWAIT;
            ST_U_SWAIT: begin
                if (status.div_done) begin
                    step_next  = MUL_LL;
                    state_next = ST_U_MUL;
                end
            end
            ST_U_MUL: begin
                step_next = mul_step_t'(step_reg + 1'b1);
                if (step_reg == MUL_HH) state_next = ST_U_MFIN;
            end
            ST_U_MFIN: begin
                step_next  = MUL_NLO;
                state_next = ST_U_NMUL;
            end
            ST_U_NMUL: begin
                step_next = mul_step_t'(step_reg + 1'b1);
                if (step_reg == MUL_NHI) state_next = ST_U_WB;
            end
            ST_U_WB: begin
                if (pairs_reg) begin
                    i_next     = adv_i;
                    j_next     = adv_j;
                    p_next     = p_reg + 1'b1;
                    state_next = ST_P_SEL;
                end else begin
                    state_next = ST_S_LAST;
                end
            end
            ST_S_LAST: begin
                if (last_reg && !diag_only) begin
                    i_next     = '0;
                    j_next     = '0;
                    p_next     = '0;
                    pairs_next = 1'b1;
                    state_next = ST_P_SEL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_P_SEL: begin
                if (i_reg == NC_IX) begin
                    state_next = ST_IDLE;
                end else if (j_reg == i_reg) begin
                    i_next = adv_i;
                    j_next = adv_j;
                    p_next = p_reg + 1'b1;
                end else begin
                    state_next = ST_U_SCALE;
                end
            end
            ST_G_OUT: begin
                if (status.out_free) begin
                    i_next = i_reg + 1'b1;
                    if (i_reg == LAST_IX) begin
                        i_next     = '0;
                        j_next     = '0;
                        p_next     = '0;
                        state_next = ST_H_SEL;
                    end
                end
            end
            ST_H_SEL: begin
                if (i_reg == NC_IX) begin
                    state_next = ST_IDLE;
                end else if (diag_only && (j_reg != i_reg)) begin
                    i_next = adv_i;
                    j_next = adv_j;
                    p_next = p_reg + 1'b1;
                end else begin
                    state_next = ST_H_OUT;
                end
            end
            ST_H_OUT: begin
                if (status.out_free) begin
                    i_next     = adv_i;
                    j_next     = adv_j;
                    p_next     = p_reg + 1'b1;
                    state_next = ST_H_SEL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.op      = DP_NOP;
        cmd.capture = 1'b0;
        cmd.row     = idx_reg;
        cmd.col     = idx_reg;
        cmd.addr    = diag_addr;
        cmd.step    = step_reg;
        cmd.last    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_TGT:     cmd.op = DP_TARGET_WR;
            ST_S_DIFF:  cmd.op = DP_DIFF;
            ST_S_DWAIT: if (status.div_done) cmd.op = DP_DELTA_FIN;
            ST_U_SCALE: cmd.op = DP_SCALE_START;
            ST_U_SWAIT: if (status.div_done) cmd.op = DP_SCALE_FIN;
            ST_U_MUL:   cmd.op = DP_MUL;
            ST_U_MFIN:  cmd.op = DP_MFIN;
            ST_U_NMUL:  cmd.op = DP_MUL;
            ST_U_WB: begin
                cmd.op = DP_COV_WB;
                if (pairs_reg) cmd.addr = p_reg;
            end
            ST_S_LAST: if (last_reg && diag_only) cmd.op = DP_COUNT_INC;
            ST_P_SEL: begin
                cmd.row  = i_reg;
                cmd.col  = j_reg;
                cmd.addr = p_reg;
                if (i_reg == NC_IX) begin
                    cmd.op = DP_COUNT_INC;
                end else if (j_reg != i_reg) begin
                    cmd.op = DP_PAIR_LOAD;
                end
            end
            ST_G_OUT: begin
                cmd.row = i_reg;
                if (status.out_free) cmd.op = DP_GRAD_OUT;
            end
            ST_H_SEL: begin
                cmd.addr = p_reg;
                if (i_reg == NC_IX) begin
                    cmd.op = DP_CLEAR;
                end else if (!(diag_only && (j_reg != i_reg))) begin
                    cmd.op = DP_COV_RD;
                end
            end
            ST_H_OUT: begin
                cmd.row  = i_reg;
                cmd.col  = j_reg;
                cmd.last = (i_reg == LAST_IX) && (j_reg == LAST_IX);
                if (status.out_free) cmd.op = DP_HESS_OUT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
            idx_reg   <= '0;
            step_reg  <= MUL_LL;
            last_reg  <= 1'b0;
            pairs_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            pairs_reg <= pairs_next;
        end
    end

`ifndef SYNTHESIS
    a_sweep_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_P_SEL) || (state_reg == ST_H_SEL)) |-> (i_reg <= NC_IX))
        else $error("triangle sweep ran past last row");
    a_pair_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_PAIR_LOAD) |-> (j_reg > i_reg))
        else $error("off-diagonal update outside upper triangle");
    a_close_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_CLEAR) |-> $past(state_reg) == ST_H_OUT)
        else $error("close run cleared without final entry");
`endif

endmodule

// File: rtl/online_mean_covariance_accumulator_unit.sv
// ----------------------------------------------------------------------------
// online_mean_covariance_accumulator_unit: running mean and covariance
// Top level: stream channels, register port, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one item per element. tuser carries the request
//   (sample, load target, close); tlast marks the last element of a vector.
//   A sample element runs two passes of the 49-step restoring divider
//   (delta, then covariance scaling) plus the multiply and write-back
//   steps. A vector-closing element with the full matrix adds one
//   scaling pass of the divider plus multiply and write-back for each of
//   the NUM_COEFFS*(NUM_COEFFS-1)/2 off-diagonal terms, skipping the
//   diagonal slots. Close emits NUM_COEFFS gradient items, then the
//   Hessian items (diagonal only, or the packed upper triangle), tlast on
//   the final one, then clears means, covariance and count.
//   Output stream (m_*): one registered item; a stalled receiver holds the
//   item and stalls the close run; input is taken again once the run has
//   ended, also while its last item still waits.
//   Register port: inverse_temperature at 0x0, diagonal_only at 0x4; write
//   only while idle. Reset clears means, targets, covariance valid bits and
//   count, and loads beta=1.0 and diagonal mode.
// ----------------------------------------------------------------------------
module online_mean_covariance_accumulator_unit #(
    parameter int NUM_COEFFS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] elem_index, [34:3] elem_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic        s_tlast,   // vector_last
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [2:0] row_index, [5:3] col_index, [53:6] entry_value
    output logic [0:0]  m_tuser,   // [0] entry_kind
    output logic        m_tlast,   // run_last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import omca_pkg::*;

    localparam logic [2:0] ADDR_BETA = 3'd0;
    localparam logic [2:0] ADDR_DIAG = 3'd4;

    logic [15:0]              beta_reg;
    logic                     diag_reg;
    logic                     cfg_wr;
    cmd_t                     cmd;
    status_t                  status;
    logic                     out_kind;
    logic [2:0]               out_row, out_col;
    logic signed [DATA_W-1:0] out_value;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= 16'd256;
            diag_reg <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr)
                ADDR_BETA: beta_reg <= pwdata[15:0];
                ADDR_DIAG: diag_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_BETA: prdata = {16'h0000, beta_reg};
            ADDR_DIAG: prdata = {31'h0, diag_reg};
            default:   prdata = '0;
        endcase
    end

    omca_ctrl #(
        .NUM_COEFFS (NUM_COEFFS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .in_req    (req_t'(s_tuser)),
        .in_index  (s_tdata[2:0]),
        .in_last   (s_tlast),
        .diag_only (diag_reg),
        .status    (status),
        .cmd       (cmd)
    );

    omca_datapath #(
        .NUM_COEFFS (NUM_COEFFS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_value  (s_tdata[34:3]),
        .beta      (beta_reg),
        .m_ready   (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_value, out_col, out_row};
    assign m_tuser = out_kind;

endmodule
